/* hdl/ple_pkg.sv */
// Shared types and constants for the positional list engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ple_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_MODIFY = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;
  } res_t;

endpackage

/* hdl/ple_if.sv */
// Valid/ready channel interfaces for command words and result words.
// Depends on ple_pkg for field widths.
`timescale 1ns / 1ps

interface ple_in_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [DATA_W-1:0] data_out;
  logic [COUNT_W-1:0]       count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output status, output data_out, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data_out, input count,
                  input is_empty, input is_full, output ready);
endinterface

/* hdl/ple_ram.sv */
// Element store: one write port, one read port with registered read data.
// Depends on ple_pkg for the word width.
`timescale 1ns / 1ps

module ple_ram import ple_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ple_ctrl.sv */
// Command sequencer: range checks, element shift loop over the store, count.
// Depends on ple_pkg; drives the ports of ple_ram.
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     slot_free,
  output logic                     res_valid,
  output res_t                     res,
  output logic                     we,
  output logic [AW-1:0]            waddr,
  output logic [DATA_W-1:0]        wdata,
  output logic [AW-1:0]            raddr,
  input  logic [DATA_W-1:0]        rdata
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt, cmd_in;
  logic [AW-1:0]     pos_m1_r, pos_m1_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     wpa_r, wpa_nxt;
  logic [LW-1:0]     length_r, length_nxt;
  logic              status_r, status_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  logic [CW-1:0]     pos_w, len_w, idx_w, pos_r_w;
  logic              pos_ok, ins_ok, ok, more, accept;

  assign cmd_in  = cmd_t'(in_command);
  assign pos_w   = CW'(in_position);
  assign len_w   = CW'(length_r);
  assign idx_w   = CW'(idx_r);
  assign pos_r_w = CW'(pos_m1_r) + CW'(1);

  assign pos_ok = (pos_w != '0) && (pos_w <= len_w);
  assign ins_ok = (len_w < CW'(DEPTH)) && (pos_w != '0) && (pos_w <= len_w + CW'(1));
  assign ok     = (cmd_in == CMD_INSERT) ? ins_ok : pos_ok;
  assign accept = (state_r == S_IDLE) && in_valid;

  // Insert walks down from the tail, remove walks up from the hole.
  assign more = (cmd_r == CMD_INSERT) ? (idx_w >= pos_r_w) : (idx_w + CW'(1) < len_w);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!ok) begin
            state_nxt = S_DONE;
          end else if (cmd_in == CMD_READ || cmd_in == CMD_MODIFY) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_FETCH: state_nxt = S_DONE;
      S_SHIFT: begin
        if (!more && !pend_r) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    res_valid  = 1'b0;
    we         = 1'b0;
    waddr      = pos_m1_r;
    wdata      = val_r;
    raddr      = '0;
    cmd_nxt    = cmd_r;
    pos_m1_nxt = pos_m1_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    pend_nxt   = pend_r;
    wpa_nxt    = wpa_r;
    length_nxt = length_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = cmd_in;
          pos_m1_nxt = AW'(pos_w - CW'(1));
          val_nxt    = in_value;
          status_nxt = !ok;
          data_nxt   = '0;
          pend_nxt   = 1'b0;
          raddr      = AW'(pos_w - CW'(1));
          idx_nxt    = (cmd_in == CMD_INSERT) ? length_r : LW'(pos_w - CW'(1));
        end
      end
      S_FETCH: begin
        data_nxt = rdata;
        if (cmd_r == CMD_MODIFY) begin
          we = 1'b1;
        end
      end
      S_SHIFT: begin
        // Retire the word fetched last cycle, fetch the next one.
        if (pend_r) begin
          we    = 1'b1;
          waddr = wpa_r;
          wdata = rdata;
        end
        if (more) begin
          pend_nxt = 1'b1;
          wpa_nxt  = idx_r[AW-1:0];
          if (cmd_r == CMD_INSERT) begin
            raddr   = AW'(idx_w - CW'(1));
            idx_nxt = LW'(idx_w - CW'(1));
          end else begin
            raddr   = AW'(idx_w + CW'(1));
            idx_nxt = LW'(idx_w + CW'(1));
          end
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_FINAL: begin
        if (cmd_r == CMD_INSERT) begin
          we         = 1'b1;
          length_nxt = LW'(len_w + CW'(1));
        end else begin
          length_nxt = LW'(len_w - CW'(1));
        end
      end
      S_DONE: res_valid = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      length_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pos_m1_r <= pos_m1_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    wpa_r    <= wpa_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
  end

  assign res.status   = status_r;
  assign res.data_out = data_r;
  assign res.count    = len_w[COUNT_W-1:0];
  assign res.is_empty = (length_r == '0);
  assign res.is_full  = (len_w == CW'(DEPTH));

endmodule

/* hdl/positional_list_engine.sv */
// Top level of the positional list engine: sequencer, element store, result register.
// Depends on ple_pkg, ple_if, ple_ram and ple_ctrl.
//
//   channel  modport  word
//   in_ch    sink     command, position, value
//   out_ch   source   status, data_out, count, is_empty, is_full
//
// Steps per command: a refused command goes straight to done; read or modify
// passes through fetch; insert or remove runs the shift loop, which moves elements
// one per cycle through the store's single read and write ports, then a final state.
// in_ch.ready is high only while the sequencer is idle; one command is in flight.
// rst_n (synchronous) empties the list; element contents are not cleared.
// A result word waits in a register; while it is unread the next command is
// worked and then held until the register frees.
`timescale 1ns / 1ps

module positional_list_engine import ple_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic              res_valid;
  res_t              res;
  logic              slot_free;

  logic              out_valid_r;
  res_t              res_r;

  // The result slot is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ch.ready;

  ple_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_command  (in_ch.command),
    .in_position (in_ch.position),
    .in_value    (in_ch.value),
    .slot_free   (slot_free),
    .res_valid   (res_valid),
    .res         (res),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .rdata       (rdata)
  );

  ple_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Hold the result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = res_r.status;
  assign out_ch.data_out = res_r.data_out;
  assign out_ch.count    = res_r.count;
  assign out_ch.is_empty = res_r.is_empty;
  assign out_ch.is_full  = res_r.is_full;

endmodule
